// ===== rtl/sha_pkg.sv =====
// SHA-256 hasher package: round constants, initial hash values and helper functions.
// Used by every module of sha256_message_hasher; no dependencies.
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned QueueDepth = 4;

  // One classified beat handed from the front part to the back part.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_message;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } core_state_e;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/sha256_message_hasher.sv =====
// Top level of the SHA-256 byte-stream hasher.
// Depends on sha_pkg, sha_front and sha_core.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   input   | in        | in_valid_i/in_ready_o | data_byte_i, has_byte_i, end_message_i
//   output  | out       | out_valid_o/out_ready_i | digest_word_o, word_index_o, last_word_o
//
// Flow: a byte beat is written into the block buffer from the idle state; a
// beat that fills the 64-byte block then runs the load, round and add states
// (one shared round unit serves every round). End of message writes padding at one byte a cycle
// (up to 64 bytes), one or two compressions, then 8 digest beats.
// The 4-entry front queue absorbs input beats while the core compresses.
// Reset is asynchronous, active low; the hash state returns to the initial
// values. Output stalls hold the digest word in place.
module sha256_message_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_message_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);
  sha_pkg::item_t item;
  logic           item_valid, item_ready;

  sha_front u_front (
    .clk_i, .rst_ni, .data_byte_i, .has_byte_i, .end_message_i, .in_valid_i, .in_ready_o,
    .item_o(item), .item_valid_o(item_valid), .item_ready_i(item_ready)
  );

  sha_core u_core (
    .clk_i, .rst_ni, .item_i(item), .item_valid_i(item_valid), .item_ready_o(item_ready),
    .digest_word_o, .word_index_o, .last_word_o, .out_valid_o, .out_ready_i
  );
endmodule

// ===== rtl/sha_front.sv =====
// Front part: takes input beats, drops empty ones, queues the rest.
// Depends on sha_pkg.
module sha_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      data_byte_i,
  input  logic            has_byte_i,
  input  logic            end_message_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output sha_pkg::item_t  item_o,
  output logic            item_valid_o,
  input  logic            item_ready_i
);
  localparam int unsigned AW = $clog2(sha_pkg::QueueDepth);

  sha_pkg::item_t       mem_q [sha_pkg::QueueDepth];
  logic [AW-1:0]        wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]          cnt_q, cnt_d;
  logic                 push, pop;

  assign in_ready_o   = (cnt_q != (AW+1)'(sha_pkg::QueueDepth));
  // beats with neither a byte nor an end mark do nothing
  assign push         = in_valid_i && in_ready_o && (has_byte_i || end_message_i);
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rd_q];

  assign wr_d  = push ? wr_q + AW'(1) : wr_q;
  assign rd_d  = pop ? rd_q + AW'(1) : rd_q;
  assign cnt_d = cnt_q + (AW+1)'(push) - (AW+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{has_byte: has_byte_i, data_byte: data_byte_i,
                       end_message: end_message_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == (AW+1)'(sha_pkg::QueueDepth) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> !pop) else $error("queue underflow");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
`endif
endmodule

// ===== rtl/sha_core.sv =====
// Back part: block buffer, padding, 64-round compression and digest output.
// Depends on sha_pkg.
module sha_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sha_pkg::item_t  item_i,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  output logic [31:0]     digest_word_o,
  output logic [2:0]      word_index_o,
  output logic            last_word_o,
  output logic            out_valid_o,
  input  logic            out_ready_i
);
  sha_pkg::core_state_e state_q, state_d;

  // block buffer kept as 16 big-endian words, written one byte lane at a time
  logic [31:0] buf_q [sha_pkg::BlockBytes/4];
  logic [31:0] w_q [16];
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [3:0]  ld_q, ld_d;     // word loader for schedule
  logic [5:0]  pad_q, pad_d;   // padding write pointer
  logic        fin_q, fin_d;   // finalizing: compressions belong to padding
  logic        last_q, last_d; // this compression is the final one
  logic [2:0]  oi_q, oi_d;

  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  logic        h_init, h_add, v_load, v_step, w_load, w_shift;

  // round datapath
  logic [31:0] s1, ch, t1, s0, mj, t2, sg0, sg1, w_new;
  always_comb begin
    s1 = sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11) ^ sha_pkg::rotr(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + s1 + ch + sha_pkg::round_k(rnd_q) + w_q[0];
    s0 = sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13) ^ sha_pkg::rotr(v_q[0], 22);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = s0 + mj;
    sg0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    sg1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = w_q[0] + sg0 + w_q[9] + sg1;
  end

  // padding byte at pad_q
  logic [7:0] pad_byte;
  always_comb begin
    if (pad_q >= 6'd56) pad_byte = bits_q[8'(63 - 8 * (pad_q - 6'd56)) -: 8];
    else pad_byte = 8'h00;
  end

  always_comb begin
    state_d = state_q;
    fill_d = fill_q; bits_d = bits_q; rnd_d = rnd_q; ld_d = ld_q; pad_d = pad_q;
    fin_d = fin_q; last_d = last_q; oi_d = oi_q;
    wr_en = 1'b0; wr_addr = fill_q; wr_data = item_i.data_byte;
    h_init = 1'b0; h_add = 1'b0; v_load = 1'b0; v_step = 1'b0;
    w_load = 1'b0; w_shift = 1'b0;
    item_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      sha_pkg::ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          if (item_i.has_byte) begin
            wr_en  = 1'b1;
            fill_d = fill_q + 6'd1;
            bits_d = bits_q + 64'd8;
          end
          if (item_i.has_byte && fill_q == 6'd63) begin
            fin_d = item_i.end_message; last_d = 1'b0;
            ld_d = '0; state_d = sha_pkg::ST_LOAD;
          end else if (item_i.end_message) begin
            fin_d = 1'b1;
            state_d = sha_pkg::ST_PAD;
            // 0x80 marker goes at the current fill position
            pad_d = item_i.has_byte ? fill_q + 6'd1 : fill_q;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        if (pad_q == fill_q && !last_q) begin
          wr_en = 1'b1; wr_addr = pad_q; wr_data = 8'h80;
          // marker at 56 or later: length goes in a second block
          last_d = (pad_q < 6'd56);
        end else begin
          wr_en = 1'b1; wr_addr = pad_q;
          wr_data = last_q ? pad_byte : 8'h00;
        end
        pad_d = pad_q + 6'd1;
        if (pad_q == 6'd63) begin
          ld_d = '0; state_d = sha_pkg::ST_LOAD;
        end
      end
      sha_pkg::ST_LOAD: begin
        w_load = 1'b1;
        ld_d = ld_q + 4'd1;
        if (ld_q == 4'd15) begin
          v_load = 1'b1; rnd_d = '0; state_d = sha_pkg::ST_ROUND;
        end
      end
      sha_pkg::ST_ROUND: begin
        v_step = 1'b1; w_shift = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(sha_pkg::Rounds - 1)) state_d = sha_pkg::ST_ADD;
      end
      sha_pkg::ST_ADD: begin
        h_add = 1'b1;
        if (!fin_q) begin
          state_d = sha_pkg::ST_IDLE;
        end else if (last_q) begin
          oi_d = '0; state_d = sha_pkg::ST_EMIT;
        end else begin
          // second padding block; fill 0 means the message ended on a full
          // block, so the marker still goes at byte 0, else zeros then length
          pad_d = '0;
          last_d = (fill_q != 6'd0);
          state_d = sha_pkg::ST_PAD;
        end
      end
      sha_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          oi_d = oi_q + 3'd1;
          if (oi_q == 3'd7) begin
            h_init = 1'b1; fill_d = '0; bits_d = '0; fin_d = 1'b0; last_d = 1'b0;
            state_d = sha_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = sha_pkg::ST_IDLE;
    endcase
  end

  // marker is written only while last_q is low, so a length block never gets one
  assign digest_word_o = h_q[oi_q];
  assign word_index_o  = oi_q;
  assign last_word_o   = (oi_q == 3'd7);

  always_ff @(posedge clk_i) begin
    if (wr_en) buf_q[wr_addr[5:2]][{~wr_addr[1:0], 3'd0} +: 8] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (w_load) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= buf_q[ld_q];
    end else if (w_shift) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end
    if (v_load) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (v_step) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::ST_IDLE;
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_hash(3'(i));
      fill_q <= '0; bits_q <= '0; rnd_q <= '0; ld_q <= '0; pad_q <= '0;
      fin_q <= 1'b0; last_q <= 1'b0; oi_q <= '0;
    end else begin
      state_q <= state_d;
      if (h_init) begin
        for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_hash(3'(i));
      end else if (h_add) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      fill_q <= fill_d; bits_q <= bits_d; rnd_q <= rnd_d; ld_q <= ld_d; pad_q <= pad_d;
      fin_q <= fin_d; last_q <= last_d; oi_q <= oi_d;
    end
  end

`ifndef SYNTH
  a_emit_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fin_q && last_q) else $error("digest before final block");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(oi_q)) else $error("emit slip");
  a_round_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha_pkg::ST_ROUND && rnd_q != 6'd63 |=> state_q == sha_pkg::ST_ROUND)
    else $error("round count");
`endif
endmodule
